[hw/rtl/asff_pkg.sv]
// Shared types, codes and constants for the antialiased splat fade framebuffer.
package asff_pkg;

  // Default store geometry
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Field widths, arithmetic constants and reset configuration values
  localparam int          POS_W      = 6;
  localparam logic [7:0]  FADE_MUL   = 8'd230;
  localparam logic [6:0]  RST_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_HEIGHT = 7'd64;
  localparam logic [7:0]  RST_BRIGHT = 8'd220;

  // Operation codes
  localparam logic [1:0] FUNC_FADE  = 2'd0;
  localparam logic [1:0] FUNC_SPLAT = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BRIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [POS_W-1:0] pos_x;
    logic [7:0]       frac_x;
    logic [POS_W-1:0] pos_y;
    logic [7:0]       frac_y;
    logic [7:0]       intensity;
    logic [7:0]       point_hue;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_hue;
    logic [7:0] pixel_sat;
    logic [7:0] pixel_val;
  } out_t;

  // One framebuffer entry
  typedef struct packed {
    logic [7:0] hue;
    logic       sat;
    logic [7:0] val;
  } pix_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FADE_RD,
    ST_FADE_WR,
    ST_MOD,
    ST_WGT,
    ST_SCALE,
    ST_CORNER,
    ST_READ_RD,
    ST_READ_MUL,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/antialiased_splat_fade_framebuffer.sv]
// Top level: HSV trail framebuffer with fade, Wu point splat and pixel read.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in_     | input     | in_valid / in_stall  | asff_pkg::in_t (operation)
//   out_    | output    | out_valid / out_stall| asff_pkg::out_t (pixel)
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time through one shared 8x8 multiplier and one store port pair.
// Fade: read then write of each active pixel through the store.
// Splat: column modulo bit by bit, then weight, scale and write for each corner.
// Read: store read, then brightness multiply. Undefined codes go straight out.
// A full, stalled output register adds the wait. After reset a clearing pass
// zeroes the store, in_stall high meanwhile. Configuration writes are always taken.
module antialiased_splat_fade_framebuffer #(
  parameter int MAX_COLS = asff_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = asff_pkg::DEF_MAX_ROWS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  asff_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output asff_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data
);
  import asff_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int RHW    = $clog2(MAX_ROWS + 1);
  localparam int COL_IW = $clog2(MAX_COLS);
  localparam int ROW_IW = $clog2(MAX_ROWS);
  localparam int BIT_W  = $clog2(POS_W);

  // Control and datapath registers
  state_t            state_r, state_nxt;
  in_t               req_r, req_nxt;
  logic [6:0]        cfg_w_r, cfg_h_r;
  logic [7:0]        cfg_b_r;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [COL_IW-1:0] col_r, col_nxt;
  logic [ROW_IW-1:0] row_r, row_nxt;
  logic [CW:0]       rem_r, rem_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [7:0]        wt_r, wt_nxt;
  logic [7:0]        v_r, v_nxt;
  out_t              res_r, res_nxt;
  out_t              out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Store
  pix_t              mem [DEPTH];
  pix_t              rdq_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  pix_t              mem_wd;

  // Shared multiplier
  logic [7:0]        mul_a, mul_b;
  logic [15:0]       prod;
  logic [16:0]       wsum, qsum;

  // Derived values
  logic [CW-1:0]     eff_w, col0, col1, ccol;
  logic [RHW-1:0]    eff_h;
  logic [6:0]        crow;
  logic              crow_ok;
  logic [AW-1:0]     fade_addr, corner_addr, read_addr;
  logic [CW:0]       mod_t;
  logic              fade_last_row, fade_last_col;
  logic              in_acc, out_acc, done_load;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign done_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp active size to the store geometry
  always_comb begin
    if (cfg_w_r == 7'd0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_w_r) > MAX_COLS) begin
      eff_w = CW'(MAX_COLS);
    end else begin
      eff_w = CW'(cfg_w_r);
    end
    if (cfg_h_r == 7'd0) begin
      eff_h = RHW'(1);
    end else if (32'(cfg_h_r) > MAX_ROWS) begin
      eff_h = RHW'(MAX_ROWS);
    end else begin
      eff_h = RHW'(cfg_h_r);
    end
  end

  // Corner column wraps; corner row clips
  assign col0        = rem_r[CW-1:0];
  assign col1        = ((col0 + CW'(1)) == eff_w) ? '0 : (col0 + CW'(1));
  assign ccol        = k_r[0] ? col1 : col0;
  assign crow        = {1'b0, req_r.pos_y} + {6'd0, k_r[1]};
  assign crow_ok     = 32'(crow) < 32'(eff_h);
  assign corner_addr = AW'(32'(ccol) * MAX_ROWS + 32'(crow));
  assign fade_addr   = AW'(32'(col_r) * MAX_ROWS + 32'(row_r));
  assign read_addr   = AW'(32'(req_r.pos_x) * MAX_ROWS + 32'(req_r.pos_y));

  assign fade_last_row = (RHW'(row_r) == (eff_h - RHW'(1)));
  assign fade_last_col = (CW'(col_r) == (eff_w - CW'(1)));

  // One restoring step of the column modulo
  assign mod_t = {rem_r[CW-1:0], req_r.pos_x[bit_r]};

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_FADE_WR: begin
        mul_a = rdq_r.val;
        mul_b = FADE_MUL;
      end
      ST_WGT: begin
        mul_a = k_r[0] ? req_r.frac_x : ~req_r.frac_x;
        mul_b = k_r[1] ? req_r.frac_y : ~req_r.frac_y;
      end
      ST_SCALE: begin
        mul_a = req_r.intensity;
        mul_b = wt_r;
      end
      ST_READ_MUL: begin
        mul_a = rdq_r.val;
        mul_b = cfg_b_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign wsum = 17'(prod) + 17'(mul_a) + 17'(mul_b);
  // Floor divide by 255 for any 8x8 product
  assign qsum = 17'(prod) + 17'(prod[15:8]) + 17'd1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            FUNC_FADE:  state_nxt = ST_FADE_RD;
            FUNC_SPLAT: state_nxt = ST_MOD;
            FUNC_READ:  state_nxt = ST_READ_RD;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FADE_RD:  state_nxt = ST_FADE_WR;
      ST_FADE_WR: begin
        state_nxt = (fade_last_row && fade_last_col) ? ST_DONE : ST_FADE_RD;
      end
      ST_MOD: begin
        if (bit_r == '0) state_nxt = ST_WGT;
      end
      ST_WGT:      state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_CORNER;
      ST_CORNER:   state_nxt = (k_r == 2'd3) ? ST_DONE : ST_WGT;
      ST_READ_RD:  state_nxt = ST_READ_MUL;
      ST_READ_MUL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_load) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
      end
      ST_FADE_RD: mem_ra = fade_addr;
      ST_FADE_WR: begin
        mem_we = 1'b1;
        mem_wa = fade_addr;
        mem_wd = '{hue: rdq_r.hue, sat: rdq_r.sat, val: prod[15:8]};
      end
      ST_SCALE:   mem_ra = corner_addr;
      ST_CORNER: begin
        mem_we = crow_ok && (v_r >= rdq_r.val);
        mem_wa = corner_addr;
        mem_wd = '{hue: req_r.point_hue, sat: 1'b1, val: v_r};
      end
      ST_READ_RD: mem_ra = read_addr;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    req_nxt       = req_r;
    clr_nxt       = clr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    wt_nxt        = wt_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_acc) out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + AW'(1);
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          res_nxt = '0;
          col_nxt = '0;
          row_nxt = '0;
          rem_nxt = '0;
          bit_nxt = BIT_W'(POS_W - 1);
          k_nxt   = '0;
        end
      end
      ST_FADE_WR: begin
        // Advance row first, then column
        if (fade_last_row) begin
          row_nxt = '0;
          col_nxt = col_r + COL_IW'(1);
        end else begin
          row_nxt = row_r + ROW_IW'(1);
        end
      end
      ST_MOD: begin
        rem_nxt = (mod_t >= (CW+1)'(eff_w)) ? (mod_t - (CW+1)'(eff_w)) : mod_t;
        bit_nxt = bit_r - BIT_W'(1);
      end
      ST_WGT:   wt_nxt = wsum[15:8];
      ST_SCALE: v_nxt  = prod[15:8];
      ST_CORNER: k_nxt = k_r + 2'd1;
      ST_READ_MUL: begin
        if (32'(req_r.pos_x) < 32'(eff_w) && 32'(req_r.pos_y) < 32'(eff_h)) begin
          res_nxt.pixel_hue = rdq_r.hue;
          res_nxt.pixel_sat = {8{rdq_r.sat}};
          res_nxt.pixel_val = qsum[15:8];
        end
      end
      ST_DONE: begin
        if (done_load) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= RST_WIDTH;
      cfg_h_r <= RST_HEIGHT;
      cfg_b_r <= RST_BRIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_w_r <= cfg_data[6:0];
        CFG_HEIGHT: cfg_h_r <= cfg_data[6:0];
        CFG_BRIGHT: cfg_b_r <= cfg_data;
        default:    cfg_b_r <= cfg_b_r;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    k_r        <= k_nxt;
    wt_r       <= wt_nxt;
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdq_r <= mem[mem_ra];
  end

endmodule

[hw/rtl/asff_check.sv]
// Port-level checker for the framebuffer, bound to the top level.
module asff_check (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input asff_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input asff_pkg::out_t out_data
);
  import asff_pkg::*;

  logic [1:0] rd_q_r, rd_q_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Track, in order, which pending items are reads: drop on output, add on input
  always_comb begin
    rd_q_nxt = rd_q_r;
    cnt_nxt  = cnt_r;
    if (out_xfer && cnt_r != 2'd0) begin
      rd_q_nxt = {1'b0, rd_q_r[1]};
      cnt_nxt  = cnt_r - 2'd1;
    end
    if (in_xfer && cnt_nxt != 2'd2) begin
      rd_q_nxt[cnt_nxt[0]] = (in_data.func == FUNC_READ);
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_q_r <= '0;
      cnt_r  <= '0;
    end else begin
      rd_q_r <= rd_q_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Reset starts the clearing pass, which holds off input
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // Saturation comes out as all zeros or all ones
  a_sat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_sat == 8'd0 || out_data.pixel_sat == 8'd255))
    else $error("bad saturation code");

  // Only a read yields a nonzero result
  a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !rd_q_r[0]) |-> (out_data == '0))
    else $error("nonzero result for a non-read operation");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind antialiased_splat_fade_framebuffer asff_check u_asff_check (.*);
